// ===== rtl/rmsprop_param_update_core_macros.svh =====
// assertion macros for the rmsprop update core
// no dependencies
`ifndef RMSPROP_PARAM_UPDATE_CORE_MACROS_SVH
`define RMSPROP_PARAM_UPDATE_CORE_MACROS_SVH
// plain implication check under reset
`define RPU_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpu check failed");
// next-cycle implication check under reset
`define RPU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpu check failed");
`endif

// ===== rtl/rpu_pkg.sv =====
// shared constants and types for the rmsprop update core
// no dependencies
package rpu_pkg;
  localparam int Entries = 4096;
  localparam int IdxW = 12;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 24;
  localparam logic [CfgIdxW-1:0] RegLr = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAlpha = 3'd1;
  localparam logic [CfgIdxW-1:0] RegEps = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWd = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMom = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCtr = 3'd5;
  localparam logic signed [39:0] V40Max = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] V40Min = 40'sh80_0000_0000;

  typedef struct packed {
    logic [23:0] lr;
    logic [15:0] alpha;
    logic [15:0] eps;
    logic [15:0] wd;
    logic [15:0] mom;
    logic        ctr;
  } cfg_t;
endpackage

// ===== rtl/rpu_isqrt.sv =====
// pipelined integer square root, one result bit per stage
// no dependencies
module rpu_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic [63:0] din,
  output logic [31:0] root
);
  // stage k: remainder and partial root after k bits
  logic [63:0] rem [0:32];
  logic [31:0] rt  [0:32];
  logic [63:0] src [0:32];

  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign src[0] = din;

  for (genvar k = 0; k < 32; k++) begin : g_stage
    logic [63:0] trial;
    logic [63:0] rem_sh;
    logic [63:0] rem_next;
    logic [31:0] rt_next;
    always_comb begin
      rem_sh = {rem[k][61:0], src[k][63:62]};
      trial = {30'd0, rt[k], 2'b01};
      if (rem_sh >= trial) begin
        rem_next = rem_sh - trial;
        rt_next = {rt[k][30:0], 1'b1};
      end else begin
        rem_next = rem_sh;
        rt_next = {rt[k][30:0], 1'b0};
      end
    end
    if (k % 4 == 3) begin : g_reg
      logic [63:0] rem_q, src_q;
      logic [31:0] rt_q;
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q <= rem_next;
          rt_q <= rt_next;
          src_q <= {src[k][61:0], 2'b00};
        end
      end
      assign rem[k+1] = rem_q;
      assign rt[k+1] = rt_q;
      assign src[k+1] = src_q;
    end else begin : g_comb
      assign rem[k+1] = rem_next;
      assign rt[k+1] = rt_next;
      assign src[k+1] = {src[k][61:0], 2'b00};
    end
  end
  assign root = rt[32];
  logic unused_rst;
  assign unused_rst = rst;
endmodule

// ===== rtl/rpu_divider.sv =====
// pipelined restoring divider, 55-bit dividend by 32-bit divisor
// depends on nothing beyond plain logic
module rpu_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic [54:0] num,
  input  logic [31:0] den,
  output logic [54:0] quo
);
  logic [32:0] rem [0:55];
  logic [54:0] q   [0:55];
  logic [31:0] dv  [0:55];

  assign rem[0] = '0;
  assign q[0]   = num;
  assign dv[0]  = den;

  // a register after every fourth bit and after the last bit: 14 stages
  for (genvar k = 0; k < 55; k++) begin : g_stage
    logic [32:0] sh;
    logic [32:0] rn;
    logic [54:0] qn;
    always_comb begin
      sh = {rem[k][31:0], q[k][54]};
      if (sh >= {1'b0, dv[k]}) begin
        rn = sh - {1'b0, dv[k]};
        qn = {q[k][53:0], 1'b1};
      end else begin
        rn = sh;
        qn = {q[k][53:0], 1'b0};
      end
    end
    if (k % 4 == 3 || k == 54) begin : g_reg
      logic [32:0] rq;
      logic [54:0] qq;
      logic [31:0] dq;
      always_ff @(posedge clk) begin
        if (en) begin
          rq <= rn;
          qq <= qn;
          dq <= dv[k];
        end
      end
      assign rem[k+1] = rq;
      assign q[k+1] = qq;
      assign dv[k+1] = dq;
    end else begin : g_comb
      assign rem[k+1] = rn;
      assign q[k+1] = qn;
      assign dv[k+1] = dv[k];
    end
  end
  assign quo = q[55];
  logic unused_rst;
  assign unused_rst = rst;
endmodule

// ===== rtl/rmsprop_param_update_core.sv =====
// top level of the rmsprop parameter update core
// depends on rpu_pkg, rpu_isqrt, rpu_divider and the assertion macro header
//
// usage: one request on s_axis carries an entry index, a parameter value and
// a gradient (both signed Q8.24); one result leaves on m_axis with the index,
// the updated parameter and a saturation flag. configuration is a plain
// write port (cfg_we, cfg_index, cfg_data), for the user to write only while
// idle; the block does not enforce this. throughput: one request per cycle
// for distinct entries unless stalled. from acceptance to m_axis_tvalid: 7
// front, 8 root, 14 divider and 4 back stages including the output register.
// per-entry state (squared mean, gradient mean, velocity) lives in three
// 4096-entry memories with one read and one write port each.
// a request for an entry already in flight waits at the input until the
// earlier one has left the pipeline, so every read sees current state.
// reset: after rst a clearing pass zeroes all 4096 entries, one per cycle;
// s_axis_tready stays low throughout the pass. configuration resets too.
// stall: when m_axis_tvalid is high and m_axis_tready is low the whole
// pipeline holds; nothing is lost or repeated and s_axis_tready drops with it.
`include "rmsprop_param_update_core_macros.svh"
module rmsprop_param_update_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // entry_index[11:0], param_value[43:12], gradient[75:44], zero fill
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_index[11:0], new_param[43:12], saturated[44], zero fill
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [rpu_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rpu_pkg::CfgDataW-1:0] cfg_data
);
  localparam int Nst = 32;  // pipeline stages ahead of the output register
  localparam int RdSt = 1;  // memory read data ready at stage 1
  localparam int WbSt = 4;  // write back stage for sq, gm
  localparam int VelSt = 26; // last stage of the velocity read delay line

  rpu_pkg::cfg_t cfg;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lr <= 24'd167772; cfg.alpha <= 16'd64881; cfg.eps <= 16'd43;
      cfg.wd <= '0; cfg.mom <= '0; cfg.ctr <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        rpu_pkg::RegLr:    cfg.lr <= cfg_data;
        rpu_pkg::RegAlpha: cfg.alpha <= cfg_data[15:0];
        rpu_pkg::RegEps:   cfg.eps <= cfg_data[15:0];
        rpu_pkg::RegWd:    cfg.wd <= cfg_data[15:0];
        rpu_pkg::RegMom:   cfg.mom <= cfg_data[15:0];
        rpu_pkg::RegCtr:   cfg.ctr <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clearing pass
  logic [rpu_pkg::IdxW:0] clr_cnt;
  logic clearing;
  assign clearing = !clr_cnt[rpu_pkg::IdxW];
  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (clearing) clr_cnt <= clr_cnt + 1'b1;
  end

  logic en;
  assign en = m_axis_tready || !m_axis_tvalid;

  // pipeline valid and index tracking for hazard detection
  logic [Nst-1:0] vld;
  logic [rpu_pkg::IdxW-1:0] pidx [0:Nst-1];
  logic [Nst-1:0] pinr;
  logic hazard;
  logic [rpu_pkg::IdxW-1:0] in_idx;
  assign in_idx = s_axis_tdata[11:0];
  always_comb begin
    hazard = 1'b0;
    for (int k = 0; k < Nst; k++)
      if (vld[k] && pidx[k] == in_idx) hazard = 1'b1;
  end
  assign s_axis_tready = en && !clearing && !hazard;
  logic take;
  assign take = s_axis_tvalid && s_axis_tready;

  // per-stage payload
  logic signed [31:0] pp [0:Nst-1];
  logic signed [31:0] pg [0:Nst-1];
  logic [Nst-1:0] psat;

  // stage 0: capture
  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= take;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pidx[0] <= in_idx;
      pinr[0] <= {20'd0, in_idx} < 32'(rpu_pkg::Entries);
      pp[0] <= $signed(s_axis_tdata[43:12]);
      pg[0] <= $signed(s_axis_tdata[75:44]);
      psat[0] <= 1'b0;
    end
  end

  for (genvar k = 1; k < Nst; k++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) vld[k] <= 1'b0;
      else if (en) vld[k] <= vld[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        pidx[k] <= pidx[k-1];
        pinr[k] <= pinr[k-1];
        pp[k] <= pp[k-1];
      end
    end
  end

  // memories
  logic [47:0] sq_mem [0:rpu_pkg::Entries-1];
  logic [31:0] gm_mem [0:rpu_pkg::Entries-1];
  logic [39:0] vel_mem [0:rpu_pkg::Entries-1];
  logic [47:0] sq_rd;
  logic [31:0] gm_rd;
  logic [39:0] vel_rd;
  always_ff @(posedge clk) begin
    if (en) begin
      sq_rd <= sq_mem[pidx[0]];
      gm_rd <= gm_mem[pidx[0]];
      vel_rd <= vel_mem[pidx[0]];
    end
  end
  // vel read value has to travel to the velocity stage
  logic [39:0] velp [RdSt+1:VelSt];
  always_ff @(posedge clk) if (en) velp[RdSt+1] <= pinr[RdSt] ? vel_rd : '0;
  for (genvar k = RdSt+2; k <= VelSt; k++) begin : g_velp
    always_ff @(posedge clk) if (en) velp[k] <= velp[k-1];
  end

  // stage 1: weight decay product
  logic signed [48:0] wdp;
  always_ff @(posedge clk) if (en) wdp <= $signed({1'b0, cfg.wd}) * pp[0];
  always_ff @(posedge clk) if (en) begin pg[1] <= pg[0]; psat[1] <= psat[0]; end

  // stage 2: decayed gradient with clamp, register memory reads
  logic signed [33:0] gsum;
  logic signed [31:0] g2s;
  logic sat2;
  always_comb begin
    gsum = 34'(pg[1]) + 34'(wdp >>> 16);
    sat2 = 1'b0;
    if (gsum > 34'sd2147483647) begin g2s = 32'sh7FFF_FFFF; sat2 = 1'b1; end
    else if (gsum < -34'sd2147483648) begin g2s = 32'sh8000_0000; sat2 = 1'b1; end
    else g2s = gsum[31:0];
  end
  logic [47:0] s_in;
  logic signed [31:0] m_in;
  always_ff @(posedge clk) if (en) begin
    pg[2] <= g2s; psat[2] <= psat[1] | sat2;
    s_in <= pinr[1] ? sq_rd : '0;
    m_in <= pinr[1] ? $signed(gm_rd) : '0;
  end

  // stage 3: g squared, alpha products
  logic [31:0] au3;
  assign au3 = pg[2][31] ? 32'(-pg[2]) : 32'(pg[2]);
  logic [63:0] gsq;
  logic [63:0] as3;
  logic signed [48:0] am3;
  logic signed [49:0] bg3;
  always_ff @(posedge clk) if (en) begin
    gsq <= au3 * au3;
    as3 <= {48'd0, cfg.alpha} * {16'd0, s_in};
    am3 <= $signed({1'b0, cfg.alpha}) * m_in;
    bg3 <= $signed({1'b0, 17'h10000 - {1'b0, cfg.alpha}}) * pg[2];
    pg[3] <= pg[2]; psat[3] <= psat[2];
  end

  // stage 4: new sq, new m (written back here, m only when cfg.ctr is set)
  logic [16:0] beta;
  assign beta = 17'h10000 - {1'b0, cfg.alpha};
  logic [47:0] g2_4;
  assign g2_4 = gsq[63:16];
  logic [65:0] bsum;
  logic [47:0] s4;
  logic signed [50:0] msum;
  logic signed [31:0] m4;
  always_comb begin
    bsum = 66'(as3) + 66'(beta) * 66'(g2_4);
    s4 = bsum[63:16];
    msum = 51'(am3) + 51'(bg3);
    m4 = msum[47:16];
  end
  logic [47:0] s_q;
  logic signed [31:0] m_q;
  always_ff @(posedge clk) if (en) begin
    s_q <= s4; m_q <= m4; pg[4] <= pg[3]; psat[4] <= psat[3];
  end
  always_ff @(posedge clk) begin
    if (clearing) begin
      sq_mem[clr_cnt[rpu_pkg::IdxW-1:0]] <= '0;
      gm_mem[clr_cnt[rpu_pkg::IdxW-1:0]] <= '0;
    end else if (en && vld[WbSt] && pinr[WbSt]) begin
      sq_mem[pidx[WbSt]] <= s_q;
      if (cfg.ctr) gm_mem[pidx[WbSt]] <= m_q;
    end
  end

  // stage 5: m squared and variance
  logic [31:0] am5;
  assign am5 = m_q[31] ? 32'(-m_q) : 32'(m_q);
  logic [63:0] msq;
  logic [47:0] s5;
  always_ff @(posedge clk) if (en) begin
    msq <= am5 * am5; s5 <= s_q; pg[5] <= pg[4]; psat[5] <= psat[4];
  end
  logic [47:0] var6;
  logic neg6;
  always_comb begin
    neg6 = cfg.ctr && (msq[63:16] > s5);
    if (!cfg.ctr) var6 = s5;
    else if (neg6) var6 = '0;
    else var6 = s5 - msq[63:16];
  end
  logic [63:0] dsh;
  always_ff @(posedge clk) if (en) begin
    dsh <= {2'b0, 48'(var6 + 48'(cfg.eps)), 14'd0};
    pg[6] <= pg[5]; psat[6] <= psat[5] | neg6;
  end
  // note: the squared mean stays below 2^47, so var + eps fits in 48 bits
  // stages 7..14: root
  logic [31:0] root;
  rpu_isqrt u_isqrt (.clk(clk), .rst(rst), .en(en), .din(dsh), .root(root));
  for (genvar k = 7; k <= 14; k++) begin : g_rp
    always_ff @(posedge clk) if (en) begin pg[k] <= pg[k-1]; psat[k] <= psat[k-1]; end
  end
  // stages 15..28: divide |g|<<23 by root (root is at stage 14 output)
  logic [54:0] quo;
  logic [31:0] au14;
  assign au14 = pg[14][31] ? 32'(-pg[14]) : 32'(pg[14]);
  rpu_divider u_div (.clk(clk), .rst(rst), .en(en), .num({au14, 23'd0}),
    .den(root), .quo(quo));
  logic [28:15] rz;
  always_ff @(posedge clk) if (en) rz[15] <= root == '0;
  for (genvar k = 15; k <= 28; k++) begin : g_dp
    always_ff @(posedge clk) if (en) begin pg[k] <= pg[k-1]; psat[k] <= psat[k-1]; end
  end
  for (genvar k = 16; k <= 28; k++) begin : g_rz
    always_ff @(posedge clk) if (en) rz[k] <= rz[k-1];
  end
  // quo valid together with stage 28
  logic signed [39:0] u29;
  logic sat29;
  always_comb begin
    sat29 = 1'b0;
    if (rz[28]) begin
      if (pg[28] == 0) u29 = '0;
      else begin u29 = pg[28][31] ? rpu_pkg::V40Min : rpu_pkg::V40Max; sat29 = 1'b1; end
    end else if (quo > 55'(rpu_pkg::V40Max)) begin
      u29 = pg[28][31] ? rpu_pkg::V40Min : rpu_pkg::V40Max; sat29 = 1'b1;
    end else u29 = pg[28][31] ? -$signed(quo[39:0]) : $signed(quo[39:0]);
  end
  logic signed [39:0] u_q;
  always_ff @(posedge clk) if (en) begin
    u_q <= u29; pg[29] <= pg[28]; psat[29] <= psat[28] | sat29;
  end
  // velocity product (stage 29 -> 30); velp is aligned to VelSt = 26, carry on
  logic [39:0] velx [27:29];
  always_ff @(posedge clk) if (en) velx[27] <= velp[VelSt];
  always_ff @(posedge clk) if (en) velx[28] <= velx[27];
  always_ff @(posedge clk) if (en) velx[29] <= velx[28];
  logic signed [56:0] mv;
  logic signed [39:0] u30;
  always_ff @(posedge clk) if (en) begin
    mv <= $signed({1'b0, cfg.mom}) * $signed(velx[29]);
    u30 <= u_q; pg[30] <= pg[29]; psat[30] <= psat[29];
  end
  logic signed [41:0] vs;
  logic signed [39:0] u31;
  logic sat31;
  always_comb begin
    vs = 42'(mv >>> 16) + 42'(u30);
    sat31 = 1'b0;
    if (cfg.mom == 0) u31 = u30;
    else if (vs > 42'(rpu_pkg::V40Max)) begin u31 = rpu_pkg::V40Max; sat31 = 1'b1; end
    else if (vs < 42'(rpu_pkg::V40Min)) begin u31 = rpu_pkg::V40Min; sat31 = 1'b1; end
    else u31 = vs[39:0];
  end
  logic signed [39:0] ufin;
  always_ff @(posedge clk) if (en) begin
    ufin <= u31; pg[31] <= pg[30]; psat[31] <= psat[30] | sat31;
  end
  always_ff @(posedge clk) begin
    if (!clearing && en && vld[30] && pinr[30] && cfg.mom != 0)
      vel_mem[pidx[30]] <= u31;
    else if (clearing) vel_mem[clr_cnt[rpu_pkg::IdxW-1:0]] <= '0;
  end

  // final: learning rate product and clamp into output register
  logic [39:0] amu;
  logic [63:0] dmp;
  logic signed [41:0] np;
  logic signed [31:0] npc;
  logic satf;
  always_comb begin
    amu = ufin[39] ? 40'(-ufin) : 40'(ufin);
    dmp = 64'(amu) * 64'(cfg.lr);
    np = ufin[39] ? 42'(pp[Nst-1]) + 42'(dmp[63:24]) : 42'(pp[Nst-1]) - 42'(dmp[63:24]);
    satf = 1'b0;
    if (np > 42'sd2147483647) begin npc = 32'sh7FFF_FFFF; satf = 1'b1; end
    else if (np < -42'sd2147483648) begin npc = 32'sh8000_0000; satf = 1'b1; end
    else npc = np[31:0];
  end
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (en) m_axis_tvalid <= vld[Nst-1];
  end
  always_ff @(posedge clk) if (en)
    m_axis_tdata <= {3'd0, psat[Nst-1] | satf, npc, pidx[Nst-1]};

  `RPU_ASSERT(a_no_take_clear, clearing, !s_axis_tready)
  `RPU_ASSERT(a_hold_stall, m_axis_tvalid && !m_axis_tready, !en)
  `RPU_ASSERT_NEXT(a_take_enters, take, vld[0])
endmodule
